// ----- rtl/core/rtt_pkg.sv -----
// Shared types and constants for the RTT estimator and retransmit timer.
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

   // Request and response field widths
   localparam int OP_W        = 3;
   localparam int SAMPLE_W    = 32;
   localparam int OUT_TIME_W  = 32;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 104;

   // Configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int ALPHA_W     = 3;
   localparam int BETA_W      = 3;
   localparam int KGAIN_W     = 4;
   localparam int GRAN_W      = 20;
   localparam int FLOOR_W     = 24;
   localparam int INIT_RTO_W  = 24;

   // Register reset values
   localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 3'd3;
   localparam logic [BETA_W-1:0]     BETA_RESET     = 3'd2;
   localparam logic [KGAIN_W-1:0]    KGAIN_RESET    = 4'd4;
   localparam logic [GRAN_W-1:0]     GRAN_RESET     = 20'd1000;
   localparam logic [FLOOR_W-1:0]    FLOOR_RESET    = 24'd200000;
   localparam logic [INIT_RTO_W-1:0] INIT_RTO_RESET = 24'd1000000;

   localparam int TIME_WIDTH_DEF = 32;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE  = 3'd0,
      OP_RESTART = 3'd1,
      OP_START   = 3'd2,
      OP_CANCEL  = 3'd3,
      OP_TICK    = 3'd4
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ALPHA    = 3'd0,
      CSR_BETA     = 3'd1,
      CSR_KGAIN    = 3'd2,
      CSR_GRAN     = 3'd3,
      CSR_FLOOR    = 3'd4,
      CSR_INIT_RTO = 3'd5
   } csr_idx_type;

endpackage

`default_nettype wire

// ----- rtl/core/rtt_estimator_retx_timer.sv -----
// RTT estimator and retransmit timer: top level.
//
// Requests enter on req_*: req_tuser carries the op (sample, restart timer,
// start if idle, cancel, tick) and req_tdata the round-trip sample in us.
// Every request yields exactly one response on rsp_*: the timeout, the
// smoothed RTT, the RTT variation, the armed flag and a retransmit flag
// that is set when a tick ran the countdown out.
// A request is registered on acceptance and, when it advances, processed by a
// single combinational pass (shift EWMA, one TIME_WIDTH x 4 multiply, the
// saturating adds and compares) and written to the response register.
// The response register drives rsp_*; one request per cycle is sustained
// while the receiver keeps rsp_tready high, because the input and output
// registers move together.
// When the receiver holds rsp_tready low, the response register holds, the
// input register fills, and req_tready drops until the response is taken.
// Synchronous reset clears both registers, the estimates and the timer and
// loads the timeout with the initial value; the csr_* port writes a register
// and must be used only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rtt_estimator_retx_timer #(
   parameter int TIME_WIDTH = rtt_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [rtt_pkg::REQ_DATA_W-1:0]  req_tdata,  // [31:0] rtt_sample_us
   input  wire logic [rtt_pkg::OP_W-1:0]        req_tuser,  // [2:0] op
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] rto_us, [63:32] srtt_us, [95:64] rttvar_us, [96] timer_running,
   // [97] retransmit, [103:98] zero
   output      logic [rtt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [rtt_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [rtt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rtt_pkg::*;

   localparam int TW = TIME_WIDTH;
   localparam int WW = ((TW > CSR_DATA_W) ? TW : CSR_DATA_W) + 5;
   localparam logic [TW-1:0] TMAX = '1;
   localparam int PAD_W = RSP_DATA_W - 3 * OUT_TIME_W - 2;

   function automatic logic [TW-1:0] clip64(input logic [63:0] v);
      return (v > 64'(TMAX)) ? TMAX : TW'(v);
   endfunction

   function automatic logic [OUT_TIME_W-1:0] sat32(input logic [TW-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_TIME_W-1:0];
   endfunction

   // Configuration registers
   logic [ALPHA_W-1:0]    alpha_ff;
   logic [BETA_W-1:0]     beta_ff;
   logic [KGAIN_W-1:0]    kgain_ff;
   logic [GRAN_W-1:0]     gran_ff;
   logic [FLOOR_W-1:0]    floor_ff;

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [OP_W-1:0]       in_op_ff;
   logic [SAMPLE_W-1:0]   in_sample_ff;

   // Estimator and timer state
   logic [TW-1:0]         srtt_ff, srtt_in;
   logic [TW-1:0]         rttvar_ff, rttvar_in;
   logic [TW-1:0]         rto_ff, rto_in;
   logic [TW-1:0]         left_ff, left_in;
   logic                  have_ff, have_in;
   logic                  armed_ff, armed_in;
   logic                  retx;

   // Response register
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic                  advance;
   logic                  take_req;

   // Datapath
   logic [TW-1:0]         s_clip, diff, var_upd, srtt_upd;
   logic [TW-1:0]         est_srtt, est_var, rto_est, rto_dbl;
   logic [TW+3:0]         prod;
   logic [WW-1:0]         var_term, rto_sum;
   logic [TW:0]           dbl;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign take_req     = req_tvalid && req_tready;
   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Sample path: first sample seeds, later ones use shift-gain EWMA
   always_comb begin
      s_clip   = clip64(64'(in_sample_ff));
      diff     = (srtt_ff > s_clip) ? (srtt_ff - s_clip) : (s_clip - srtt_ff);
      var_upd  = rttvar_ff - (rttvar_ff >> beta_ff) + (diff >> beta_ff);
      srtt_upd = srtt_ff - (srtt_ff >> alpha_ff) + (s_clip >> alpha_ff);
      if (have_ff) begin
         est_srtt = srtt_upd;
         est_var  = var_upd;
      end else begin
         est_srtt = s_clip;
         est_var  = s_clip >> 1;
      end
      prod     = (TW+4)'(est_var) * (TW+4)'(kgain_ff);
      var_term = (WW'(prod) < WW'(gran_ff)) ? WW'(gran_ff) : WW'(prod);
      rto_sum  = WW'(est_srtt) + var_term;
      rto_est  = (rto_sum > WW'(TMAX)) ? TMAX : rto_sum[TW-1:0];
      if (have_ff && (WW'(rto_est) < WW'(floor_ff))) begin
         rto_est = clip64(64'(floor_ff));
      end
      dbl      = {1'b0, rto_ff} + {1'b0, rto_ff};
      rto_dbl  = dbl[TW] ? TMAX : dbl[TW-1:0];
   end

   // Next state for the request in the input register
   always_comb begin
      srtt_in   = srtt_ff;
      rttvar_in = rttvar_ff;
      rto_in    = rto_ff;
      left_in   = left_ff;
      have_in   = have_ff;
      armed_in  = armed_ff;
      retx      = 1'b0;
      if (advance) begin
         unique case (in_op_ff)
            OP_SAMPLE: begin
               srtt_in   = est_srtt;
               rttvar_in = est_var;
               rto_in    = rto_est;
               have_in   = 1'b1;
            end
            OP_RESTART: begin
               left_in  = rto_ff;
               armed_in = 1'b1;
            end
            OP_START: begin
               if (!armed_ff) begin
                  left_in  = rto_ff;
                  armed_in = 1'b1;
               end
            end
            OP_CANCEL: begin
               left_in  = '0;
               armed_in = 1'b0;
            end
            OP_TICK: begin
               if (armed_ff) begin
                  if (left_ff <= TW'(1)) begin
                     retx    = 1'b1;
                     rto_in  = rto_dbl;
                     left_in = rto_dbl;
                  end else begin
                     left_in = left_ff - TW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (csr_we && (csr_addr == CSR_INIT_RTO) && !have_ff) begin
         rto_in = clip64(64'(csr_wdata[INIT_RTO_W-1:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         beta_ff      <= BETA_RESET;
         kgain_ff     <= KGAIN_RESET;
         gran_ff      <= GRAN_RESET;
         floor_ff     <= FLOOR_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         srtt_ff      <= '0;
         rttvar_ff    <= '0;
         rto_ff       <= clip64(64'(INIT_RTO_RESET));
         left_ff      <= '0;
         have_ff      <= 1'b0;
         armed_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ALPHA:    alpha_ff    <= csr_wdata[ALPHA_W-1:0];
               CSR_BETA:     beta_ff     <= csr_wdata[BETA_W-1:0];
               CSR_KGAIN:    kgain_ff    <= csr_wdata[KGAIN_W-1:0];
               CSR_GRAN:     gran_ff     <= csr_wdata[GRAN_W-1:0];
               CSR_FLOOR:    floor_ff    <= csr_wdata[FLOOR_W-1:0];
               // only matters before the first sample; loads rto_ff directly
               CSR_INIT_RTO: begin
               end
               default: begin
               end
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         srtt_ff      <= srtt_in;
         rttvar_ff    <= rttvar_in;
         rto_ff       <= rto_in;
         left_ff      <= left_in;
         have_ff      <= have_in;
         armed_ff     <= armed_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_op_ff     <= req_tuser;
         in_sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (advance) begin
         out_data_ff <= {PAD_W'(0), retx, armed_in, sat32(rttvar_in), sat32(srtt_in),
                         sat32(rto_in)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_retx_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3*OUT_TIME_W+1] |-> rsp_tdata[3*OUT_TIME_W])
      else $error("retransmit reported with timer idle");

   a_cancel_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (in_op_ff == OP_CANCEL) |=> !armed_ff && (left_ff == '0))
      else $error("cancel did not clear the timer");

   a_have_sticky: assert property (@(posedge clock) disable iff (reset)
      have_ff |=> have_ff)
      else $error("sample flag dropped");

   a_tick_no_shrink: assert property (@(posedge clock) disable iff (reset)
      advance && (in_op_ff == OP_TICK) |=> rto_ff >= $past(rto_ff))
      else $error("tick reduced the timeout");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the RTT estimator and retransmit timer.
`timescale 1ns / 1ps

module tb;
   import rtt_pkg::*;

   // op codes the block ignores, and register indexes with no register behind them
   localparam logic [OP_W-1:0]       OP_SPARE_5  = 3'd5;
   localparam logic [OP_W-1:0]       OP_SPARE_6  = 3'd6;
   localparam logic [OP_W-1:0]       OP_SPARE_7  = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
   localparam logic [31:0] R0   = 32'd1000000;
   localparam int QUIET_LIMIT   = 1000;
   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [31:0] rto;
      logic [31:0] srtt;
      logic [31:0] rttvar;
      logic        running;
      logic        retx;
   } timer_report_type;

   typedef struct packed {
      logic             is_cfg;
      logic [2:0]       code;      // op, or register index for a write
      logic [31:0]      value;     // rtt sample, or write data
      logic             typed;
      timer_report_type expv;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rtt_estimator_retx_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // estimator state as the block should hold it
   logic [ALPHA_W-1:0]    alpha_q = ALPHA_RESET;
   logic [BETA_W-1:0]     beta_q  = BETA_RESET;
   logic [KGAIN_W-1:0]    kgain_q = KGAIN_RESET;
   logic [GRAN_W-1:0]     gran_q  = GRAN_RESET;
   logic [FLOOR_W-1:0]    floor_q = FLOOR_RESET;
   logic [INIT_RTO_W-1:0] init_q  = INIT_RTO_RESET;
   logic [31:0] srtt_q   = '0;
   logic [31:0] rttvar_q = '0;
   logic [31:0] rto_q    = 32'(INIT_RTO_RESET);
   logic [31:0] left_q   = '0;
   logic        sampled_q = 1'b0;
   logic        armed_q   = 1'b0;

   timer_report_type pending_reports[$];
   int fault_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   plan_row_type directed_plan [41] = '{
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{R0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{1'b0, OP_SPARE_5,  ALL1,  1'b1, '{R0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{1'b0, OP_CANCEL,   32'd0, 1'b1, '{R0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{1'b0, OP_START,    32'd0, 1'b1, '{R0, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_START,    32'd0, 1'b1, '{R0, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_SPARE_7,  32'd0, 1'b1, '{R0, 32'd0, 32'd0, 1'b1, 1'b0}},
      // no sample yet, so the initial timeout write loads rto directly
      '{1'b1, CSR_INIT_RTO, 32'd1, 1'b0, '0},
      '{1'b0, OP_RESTART,  32'd0, 1'b1, '{32'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{32'd2, 32'd0, 32'd0, 1'b1, 1'b1}},
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{32'd2, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{32'd4, 32'd0, 32'd0, 1'b1, 1'b1}},
      // zero countdown expires on the first tick and stays at zero
      '{1'b1, CSR_INIT_RTO, 32'd0, 1'b0, '0},
      '{1'b0, OP_CANCEL,   32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0}},
      '{1'b0, OP_RESTART,  32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{32'd0, 32'd0, 32'd0, 1'b1, 1'b1}},
      // arm with one tick left, then push rto to the top: expiry must saturate
      '{1'b1, CSR_INIT_RTO, 32'd1, 1'b0, '0},
      '{1'b0, OP_RESTART,  32'd0, 1'b1, '{32'd1, 32'd0, 32'd0, 1'b1, 1'b0}},
      '{1'b0, OP_SAMPLE,   ALL1,  1'b1, '{ALL1, ALL1, 32'h7FFF_FFFF, 1'b1, 1'b0}},
      '{1'b0, OP_TICK,     32'd0, 1'b1, '{ALL1, ALL1, 32'h7FFF_FFFF, 1'b1, 1'b1}},
      '{1'b0, OP_SPARE_6,  ALL1,  1'b0, '0},
      '{1'b1, CSR_KGAIN,   32'd0,        1'b0, '0},
      '{1'b1, CSR_GRAN,    32'hFF_FFFF,  1'b0, '0},
      '{1'b1, CSR_FLOOR,   32'hFF_FFFF,  1'b0, '0},
      '{1'b1, CSR_ALPHA,   32'd0,        1'b0, '0},
      '{1'b1, CSR_BETA,    32'd0,        1'b0, '0},
      '{1'b0, OP_SAMPLE,   32'd0, 1'b0, '0},
      '{1'b0, OP_TICK,     32'd0, 1'b0, '0},
      '{1'b1, CSR_ALPHA,   32'hFF_FFFF,  1'b0, '0},
      '{1'b1, CSR_BETA,    32'd7,        1'b0, '0},
      '{1'b1, CSR_KGAIN,   32'd15,       1'b0, '0},
      '{1'b1, CSR_GRAN,    32'd0,        1'b0, '0},
      '{1'b1, CSR_FLOOR,   32'd0,        1'b0, '0},
      '{1'b0, OP_SAMPLE,   32'd1,         1'b0, '0},
      '{1'b0, OP_SAMPLE,   32'h8000_0000, 1'b0, '0},
      '{1'b0, OP_SAMPLE,   32'h7FFF_FFFF, 1'b0, '0},
      // writes past the last register do nothing; init write after a sample leaves rto
      '{1'b1, CSR_SPARE_6, 32'hFF_FFFF,  1'b0, '0},
      '{1'b1, CSR_SPARE_7, 32'hFF_FFFF,  1'b0, '0},
      '{1'b1, CSR_INIT_RTO, 32'hFF_FFFF, 1'b0, '0},
      '{1'b0, OP_CANCEL,   32'd0, 1'b0, '0},
      '{1'b0, OP_TICK,     32'd0, 1'b0, '0},
      '{1'b0, OP_START,    32'd0, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? ALL1 : s[31:0];
   endfunction

   function automatic logic [31:0] timeout_from_estimates();
      logic [35:0] prod;
      logic [31:0] var_term;
      prod = {4'b0, rttvar_q} * {32'b0, kgain_q};
      var_term = (|prod[35:32]) ? ALL1 : prod[31:0];
      if (var_term < {12'b0, gran_q}) var_term = {12'b0, gran_q};
      return add_sat(srtt_q, var_term);
   endfunction

   task automatic step_estimator(input logic [2:0] code, input logic [31:0] sample,
                                 output timer_report_type rpt);
      logic [31:0] diff;
      logic expired;
      expired = 1'b0;
      case (code)
         OP_SAMPLE: begin
            if (!sampled_q) begin
               srtt_q = sample;
               rttvar_q = sample >> 1;
               rto_q = timeout_from_estimates();
               sampled_q = 1'b1;
            end else begin
               diff = (srtt_q > sample) ? srtt_q - sample : sample - srtt_q;
               rttvar_q = rttvar_q - (rttvar_q >> beta_q) + (diff >> beta_q);
               srtt_q = srtt_q - (srtt_q >> alpha_q) + (sample >> alpha_q);
               rto_q = timeout_from_estimates();
               if (rto_q < {8'b0, floor_q}) rto_q = {8'b0, floor_q};
            end
         end
         OP_RESTART: begin
            left_q = rto_q;
            armed_q = 1'b1;
         end
         OP_START: begin
            if (!armed_q) begin
               left_q = rto_q;
               armed_q = 1'b1;
            end
         end
         OP_CANCEL: begin
            armed_q = 1'b0;
            left_q = '0;
         end
         OP_TICK: begin
            if (armed_q) begin
               if (left_q <= 32'd1) begin
                  expired = 1'b1;
                  rto_q = add_sat(rto_q, rto_q);
                  left_q = rto_q;
               end else begin
                  left_q = left_q - 32'd1;
               end
            end
         end
         default: ;
      endcase
      rpt = '{rto_q, srtt_q, rttvar_q, armed_q, expired};
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ALPHA: alpha_q = val[ALPHA_W-1:0];
         CSR_BETA:  beta_q  = val[BETA_W-1:0];
         CSR_KGAIN: kgain_q = val[KGAIN_W-1:0];
         CSR_GRAN:  gran_q  = val[GRAN_W-1:0];
         CSR_FLOOR: floor_q = val[FLOOR_W-1:0];
         CSR_INIT_RTO: begin
            init_q = val[INIT_RTO_W-1:0];
            if (!sampled_q) rto_q = {8'b0, init_q};
         end
         default: ;
      endcase
   endtask

   // returns at the edge where the request was taken
   task automatic send_request(input logic [2:0] code, input logic [31:0] sample,
                               output timer_report_type rpt);
      csr_we <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_estimator(code, sample, rpt);
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, label, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin : check_responses
      timer_report_type want;
      timer_report_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                  rsp_tdata[96], rsp_tdata[97]};
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none got %h", $time, rsp_tdata);
            fault_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("rto_us", want.rto, seen.rto);
            check_field("srtt_us", want.srtt, seen.srtt);
            check_field("rttvar_us", want.rttvar, seen.rttvar);
            check_field("timer_running", 32'(want.running), 32'(seen.running));
            check_field("retransmit", 32'(want.retx), 32'(seen.retx));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("rtt_estimator_retx_timer: mismatch");
         $finish;
      end
   end

   function automatic logic [31:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 32'($urandom_range(0, 6));
      if (r < 80) return 32'($urandom_range(0, 200));
      if (r < 90) return $urandom;
      if (r < 95) return 32'd0;
      return ALL1;
   endfunction

   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return OP_SAMPLE;
      if (r < 23) return OP_RESTART;
      if (r < 29) return OP_START;
      if (r < 33) return OP_CANCEL;
      if (r < 37) return 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
      return OP_TICK;
   endfunction

   initial begin : stimulus
      timer_report_type rpt;
      logic [2:0] code;
      logic wide;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg) begin
            drain_reports();
            write_reg(directed_plan[i].code, directed_plan[i].value[23:0]);
         end else begin
            send_request(directed_plan[i].code, directed_plan[i].value, rpt);
            pending_reports.push_back(directed_plan[i].typed ? directed_plan[i].expv : rpt);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_reports();
         send_idle_pct = (ph == 1) ? 75 : (ph == 3) ? 8 : 0;
         stall_pct     = (ph == 2) ? 75 : (ph == 3) ? 8 : 0;
         // small timing values keep expiries frequent; the last phase goes wide
         wide = (ph == PHASES - 1);
         write_reg(CSR_ALPHA, 24'($urandom));
         write_reg(CSR_BETA, 24'($urandom));
         write_reg(CSR_KGAIN, 24'($urandom));
         write_reg(CSR_GRAN, wide ? 24'($urandom) : 24'($urandom_range(0, 4)));
         write_reg(CSR_FLOOR, wide ? 24'($urandom) : 24'($urandom_range(0, 8)));
         write_reg(CSR_INIT_RTO, wide ? 24'($urandom) : 24'($urandom_range(0, 16)));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            code = pick_op();
            send_request(code, (code == OP_SAMPLE) ? pick_sample() : $urandom, rpt);
            pending_reports.push_back(rpt);
         end
      end

      drain_reports();
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("rtt_estimator_retx_timer: match");
      end else begin
         $display("rtt_estimator_retx_timer: mismatch");
      end
      $finish;
   end

endmodule

// ----- rtt_estimator_retx_timer.f -----
rtl/core/rtt_pkg.sv
rtl/core/rtt_estimator_retx_timer.sv
bench/tb.sv
